@@ rtl/pwd_pkg.sv @@
// Shared types, constants and the CORDIC arctangent table of the waypoint decimator.
`default_nettype none

package pwd_pkg;

   // Distance threshold register
   localparam int unsigned THR_WIDTH = 31;
   localparam logic [THR_WIDTH-1:0] THR_RESET = 31'd65536;

   // CORDIC datapath: vector magnitude is normalized to 2^50, angles are 2^32 per turn
   localparam int unsigned XY_WIDTH = 56;
   localparam int unsigned ANG_WIDTH = 34;
   localparam int unsigned COARSE_SHIFT = 8;
   localparam logic signed [XY_WIDTH-1:0] NORM_LIMIT = XY_WIDTH'(64'h4_0000_0000_0000);
   localparam logic signed [XY_WIDTH-1:0] COARSE_LIMIT = XY_WIDTH'(64'h400_0000_0000);
   localparam logic signed [XY_WIDTH-1:0] K_GAIN = XY_WIDTH'(64'd652032874);
   localparam logic signed [ANG_WIDTH-1:0] HALF_TURN = ANG_WIDTH'(64'h8000_0000);

   typedef enum logic [1:0] {
      FR_TAKE,
      FR_SQUARE,
      FR_DECIDE
   } front_state_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_NORM,
      BK_VEC,
      BK_HALF,
      BK_ROT,
      BK_EMIT_HELD,
      BK_EMIT_LAST
   } back_state_type;

   // Control part of a command from the front to the heading unit
   typedef struct packed {
      logic single;
      logic last;
   } cmd_ctl_type;

   localparam int unsigned CTL_WIDTH = $bits(cmd_ctl_type);

   // atan(2^-k) in binary angle units
   function automatic logic signed [ANG_WIDTH-1:0] atan_lut(input logic [4:0] k);
      logic [31:0] v;
      unique case (k)
         5'd0:  v = 32'd536870912;
         5'd1:  v = 32'd316933406;
         5'd2:  v = 32'd167458907;
         5'd3:  v = 32'd85004756;
         5'd4:  v = 32'd42667331;
         5'd5:  v = 32'd21354465;
         5'd6:  v = 32'd10679838;
         5'd7:  v = 32'd5340245;
         5'd8:  v = 32'd2670163;
         5'd9:  v = 32'd1335087;
         5'd10: v = 32'd667544;
         5'd11: v = 32'd333772;
         5'd12: v = 32'd166886;
         5'd13: v = 32'd83443;
         5'd14: v = 32'd41722;
         5'd15: v = 32'd20861;
         5'd16: v = 32'd10430;
         5'd17: v = 32'd5215;
         5'd18: v = 32'd2608;
         5'd19: v = 32'd1304;
         5'd20: v = 32'd652;
         5'd21: v = 32'd326;
         5'd22: v = 32'd163;
         5'd23: v = 32'd81;
         5'd24: v = 32'd41;
         5'd25: v = 32'd20;
         5'd26: v = 32'd10;
         5'd27: v = 32'd5;
         5'd28: v = 32'd3;
         5'd29: v = 32'd1;
         5'd30: v = 32'd1;
         5'd31: v = 32'd0;
      endcase
      return signed'(ANG_WIDTH'(v));
   endfunction

endpackage

`default_nettype wire

@@ rtl/path_waypoint_decimator.sv @@
// Top level of the path waypoint decimator: threshold register, front, queues, heading unit.
//
//   channel  ports                                        handshake        beat
//   req      req_pos_*, req_in_orient_*, req_last_of_path push / full      one waypoint
//   rsp      rsp_out_*, rsp_heading_*, rsp_path_end       pop / empty      one emitted waypoint
//   csr      csr_distance_threshold                       csr_valid/ready  threshold write
//
// The input register holds each beat until the front takes it, so a first point of a
// path is taken directly; a point of an open path then passes subtract and per-axis
// compare, square, and sum and compare, while the next beat can wait in the register.
// A kept point holds the shared CORDIC through load, normalize, vectoring, halve,
// rotation and one or two result beats; a coincident point skips vectoring and a
// single point goes from load straight to its result beat. A four-entry
// command queue lets the keep test run ahead. Reset is synchronous and clears the held
// point, the open-path flag and both queues; the threshold returns to 1.0 m. A full
// result queue stalls the heading unit; once the command queue fills, the input stalls.
`default_nettype none

module path_waypoint_decimator #(
   parameter int POS_WIDTH = 32,
   parameter int ORIENT_WIDTH = 16,
   parameter int CORDIC_STEPS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   output logic                           full,
   input  logic signed [POS_WIDTH-1:0]    req_pos_x,
   input  logic signed [POS_WIDTH-1:0]    req_pos_y,
   input  logic signed [POS_WIDTH-1:0]    req_pos_z,
   input  logic signed [ORIENT_WIDTH-1:0] req_in_orient_w,
   input  logic signed [ORIENT_WIDTH-1:0] req_in_orient_z,
   input  logic                           req_last_of_path,
   output logic                           empty,
   input  logic                           pop,
   output logic signed [POS_WIDTH-1:0]    rsp_out_x,
   output logic signed [POS_WIDTH-1:0]    rsp_out_y,
   output logic signed [POS_WIDTH-1:0]    rsp_out_z,
   output logic signed [ORIENT_WIDTH-1:0] rsp_heading_w,
   output logic signed [ORIENT_WIDTH-1:0] rsp_heading_z,
   output logic                           rsp_path_end,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [pwd_pkg::THR_WIDTH-1:0]  csr_distance_threshold
);
   import pwd_pkg::*;

   localparam int CMD_WIDTH = CTL_WIDTH + 6 * POS_WIDTH + 2 * (POS_WIDTH + 1) + 2 * ORIENT_WIDTH;
   localparam int RSP_WIDTH = 3 * POS_WIDTH + 2 * ORIENT_WIDTH + 1;
   localparam int QUEUE_DEPTH = 4;

   logic [THR_WIDTH-1:0] thr_ff, thr_in;
   logic                 cmd_push, cmd_full, cmd_pop, cmd_empty;
   logic [CMD_WIDTH-1:0] cmd_wdata, cmd_rdata;
   logic                 rsp_push, rsp_full;
   logic [RSP_WIDTH-1:0] rsp_wdata, rsp_rdata;

   // Threshold register
   assign csr_ready = 1'b1;
   assign thr_in    = csr_valid ? csr_distance_threshold : thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else begin
         thr_ff <= thr_in;
      end
   end

   pwd_front #(
      .POS_WIDTH    (POS_WIDTH),
      .ORIENT_WIDTH (ORIENT_WIDTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .full         (full),
      .pos_x        (req_pos_x),
      .pos_y        (req_pos_y),
      .pos_z        (req_pos_z),
      .orient_w     (req_in_orient_w),
      .orient_z     (req_in_orient_z),
      .last_of_path (req_last_of_path),
      .threshold    (thr_ff),
      .cmd_full     (cmd_full),
      .cmd_push     (cmd_push),
      .cmd_data     (cmd_wdata)
   );

   pwd_fifo #(
      .WIDTH (CMD_WIDTH),
      .DEPTH (QUEUE_DEPTH)
   ) u_cmd_q (
      .clock (clock),
      .reset (reset),
      .push  (cmd_push),
      .wdata (cmd_wdata),
      .full  (cmd_full),
      .pop   (cmd_pop),
      .rdata (cmd_rdata),
      .empty (cmd_empty)
   );

   pwd_back #(
      .POS_WIDTH    (POS_WIDTH),
      .ORIENT_WIDTH (ORIENT_WIDTH),
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .cmd_data  (cmd_rdata),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp_data  (rsp_wdata)
   );

   pwd_fifo #(
      .WIDTH (RSP_WIDTH),
      .DEPTH (QUEUE_DEPTH)
   ) u_rsp_q (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push),
      .wdata (rsp_wdata),
      .full  (rsp_full),
      .pop   (pop),
      .rdata (rsp_rdata),
      .empty (empty)
   );

   // Split the result beat onto its ports
   assign {rsp_out_x, rsp_out_y, rsp_out_z, rsp_heading_w, rsp_heading_z, rsp_path_end} =
      rsp_rdata;

endmodule

`default_nettype wire

@@ rtl/pwd_fifo.sv @@
// Small show-ahead queue used between front and heading unit and on the result side.
`default_nettype none

module pwd_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);
   localparam int PTR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_WIDTH = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]     mem [DEPTH];
   logic [PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0] count_ff, count_in;
   logic                 do_push, do_pop;

   assign full    = (count_ff == CNT_WIDTH'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem[rd_ptr_ff];

   // Advance pointers, wrap at the depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_WIDTH'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_WIDTH'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the incoming beat
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= wdata;
      end
   end

endmodule

`default_nettype wire

@@ rtl/pwd_front.sv @@
// Front end: takes waypoints, runs the distance test and issues keep and single-point commands.
`default_nettype none

module pwd_front #(
   parameter int POS_WIDTH = 32,
   parameter int ORIENT_WIDTH = 16
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      push,
   output logic                                      full,
   input  logic signed [POS_WIDTH-1:0]               pos_x,
   input  logic signed [POS_WIDTH-1:0]               pos_y,
   input  logic signed [POS_WIDTH-1:0]               pos_z,
   input  logic signed [ORIENT_WIDTH-1:0]            orient_w,
   input  logic signed [ORIENT_WIDTH-1:0]            orient_z,
   input  logic                                      last_of_path,
   input  logic [pwd_pkg::THR_WIDTH-1:0]             threshold,
   input  logic                                      cmd_full,
   output logic                                      cmd_push,
   output logic [pwd_pkg::CTL_WIDTH+6*POS_WIDTH+2*(POS_WIDTH+1)+2*ORIENT_WIDTH-1:0] cmd_data
);
   import pwd_pkg::*;

   localparam int DIFF_WIDTH = POS_WIDTH + 1;
   localparam int MAG_WIDTH  = (DIFF_WIDTH > THR_WIDTH) ? DIFF_WIDTH : THR_WIDTH;
   localparam int SQ_WIDTH   = 2 * THR_WIDTH;
   localparam int SUM_WIDTH  = SQ_WIDTH + 2;

   // Input holding register
   logic                           buf_vld_ff;
   logic signed [POS_WIDTH-1:0]    buf_x_ff, buf_y_ff, buf_z_ff;
   logic signed [ORIENT_WIDTH-1:0] buf_ow_ff, buf_oz_ff;
   logic                           buf_last_ff;

   // Held point of the open path
   logic signed [POS_WIDTH-1:0]    held_x_ff, held_y_ff, held_z_ff;
   logic                           open_ff;

   // Point under test
   logic signed [POS_WIDTH-1:0]    wk_x_ff, wk_y_ff, wk_z_ff;
   logic                           wk_last_ff;
   logic signed [DIFF_WIDTH-1:0]   dx_ff, dy_ff;
   logic [THR_WIDTH-1:0]           ax_ff, ay_ff, az_ff;
   logic                           far_ff;
   logic [SQ_WIDTH-1:0]            sq_x_ff, sq_y_ff, sq_z_ff, thr_sq_ff;

   front_state_type                state_ff, state_in;

   logic signed [DIFF_WIDTH-1:0]   dx, dy, dz;
   logic [DIFF_WIDTH-1:0]          ax, ay, az;
   logic                           far_now;
   logic [SUM_WIDTH-1:0]           dist_sq;
   logic                           keep;
   logic                           buf_pop;
   logic                           advance;
   cmd_ctl_type                    ctl;

   function automatic logic [DIFF_WIDTH-1:0] abs_diff(input logic signed [DIFF_WIDTH-1:0] d);
      return d[DIFF_WIDTH-1] ? DIFF_WIDTH'(-d) : DIFF_WIDTH'(d);
   endfunction

   assign full = buf_vld_ff;

   // Differences to the held point and the per-axis test
   assign dx = {buf_x_ff[POS_WIDTH-1], buf_x_ff} - {held_x_ff[POS_WIDTH-1], held_x_ff};
   assign dy = {buf_y_ff[POS_WIDTH-1], buf_y_ff} - {held_y_ff[POS_WIDTH-1], held_y_ff};
   assign dz = {buf_z_ff[POS_WIDTH-1], buf_z_ff} - {held_z_ff[POS_WIDTH-1], held_z_ff};
   assign ax = abs_diff(dx);
   assign ay = abs_diff(dy);
   assign az = abs_diff(dz);
   assign far_now = (MAG_WIDTH'(ax) > MAG_WIDTH'(threshold)) ||
                    (MAG_WIDTH'(ay) > MAG_WIDTH'(threshold)) ||
                    (MAG_WIDTH'(az) > MAG_WIDTH'(threshold));

   // Squared distance against squared threshold
   assign dist_sq = SUM_WIDTH'(sq_x_ff) + SUM_WIDTH'(sq_y_ff) + SUM_WIDTH'(sq_z_ff);
   assign keep    = far_ff || (dist_sq > SUM_WIDTH'(thr_sq_ff)) || wk_last_ff;
   assign advance = !keep || !cmd_full;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FR_TAKE: begin
            if (buf_vld_ff && open_ff) begin
               state_in = FR_SQUARE;
            end
         end
         FR_SQUARE: state_in = FR_DECIDE;
         FR_DECIDE: begin
            if (advance) begin
               state_in = FR_TAKE;
            end
         end
         default: state_in = FR_TAKE;
      endcase
   end

   // Outputs: buffer release and command push
   always_comb begin
      buf_pop  = 1'b0;
      cmd_push = 1'b0;
      unique case (state_ff)
         FR_TAKE: begin
            buf_pop  = buf_vld_ff && (open_ff || !buf_last_ff || !cmd_full);
            cmd_push = buf_vld_ff && !open_ff && buf_last_ff && !cmd_full;
         end
         FR_DECIDE: cmd_push = keep && !cmd_full;
         default: begin
            buf_pop  = 1'b0;
            cmd_push = 1'b0;
         end
      endcase
   end

   // Build the command: single point from the buffer, keep from the held and work registers
   always_comb begin
      if (state_ff == FR_TAKE) begin
         ctl.single = 1'b1;
         ctl.last   = 1'b1;
         cmd_data   = {ctl, buf_x_ff, buf_y_ff, buf_z_ff, buf_x_ff, buf_y_ff, buf_z_ff,
                       DIFF_WIDTH'(0), DIFF_WIDTH'(0), buf_ow_ff, buf_oz_ff};
      end else begin
         ctl.single = 1'b0;
         ctl.last   = wk_last_ff;
         cmd_data   = {ctl, held_x_ff, held_y_ff, held_z_ff, wk_x_ff, wk_y_ff, wk_z_ff,
                       dx_ff, dy_ff, buf_ow_ff, buf_oz_ff};
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= FR_TAKE;
         buf_vld_ff <= 1'b0;
         open_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (push && !buf_vld_ff) begin
            buf_vld_ff <= 1'b1;
         end else if (buf_pop) begin
            buf_vld_ff <= 1'b0;
         end
         if (buf_pop && !open_ff) begin
            open_ff <= !buf_last_ff;
         end else if ((state_ff == FR_DECIDE) && keep && !cmd_full && wk_last_ff) begin
            open_ff <= 1'b0;
         end
      end
   end

   // Capture the incoming beat
   always_ff @(posedge clock) begin
      if (push && !buf_vld_ff) begin
         buf_x_ff    <= pos_x;
         buf_y_ff    <= pos_y;
         buf_z_ff    <= pos_z;
         buf_ow_ff   <= orient_w;
         buf_oz_ff   <= orient_z;
         buf_last_ff <= last_of_path;
      end
   end

   // Held point: first point of a path, or a kept point
   always_ff @(posedge clock) begin
      if (reset) begin
         held_x_ff <= '0;
         held_y_ff <= '0;
         held_z_ff <= '0;
      end else if (buf_pop && !open_ff) begin
         held_x_ff <= buf_x_ff;
         held_y_ff <= buf_y_ff;
         held_z_ff <= buf_z_ff;
      end else if ((state_ff == FR_DECIDE) && keep && !cmd_full) begin
         held_x_ff <= wk_x_ff;
         held_y_ff <= wk_y_ff;
         held_z_ff <= wk_z_ff;
      end
   end

   // Distance pipeline: differences, then squares
   always_ff @(posedge clock) begin
      if (buf_pop && open_ff) begin
         wk_x_ff    <= buf_x_ff;
         wk_y_ff    <= buf_y_ff;
         wk_z_ff    <= buf_z_ff;
         wk_last_ff <= buf_last_ff;
         dx_ff      <= dx;
         dy_ff      <= dy;
         ax_ff      <= THR_WIDTH'(ax);
         ay_ff      <= THR_WIDTH'(ay);
         az_ff      <= THR_WIDTH'(az);
         far_ff     <= far_now;
      end
      if (state_ff == FR_SQUARE) begin
         sq_x_ff   <= SQ_WIDTH'(ax_ff) * SQ_WIDTH'(ax_ff);
         sq_y_ff   <= SQ_WIDTH'(ay_ff) * SQ_WIDTH'(ay_ff);
         sq_z_ff   <= SQ_WIDTH'(az_ff) * SQ_WIDTH'(az_ff);
         thr_sq_ff <= SQ_WIDTH'(threshold) * SQ_WIDTH'(threshold);
      end
   end

endmodule

`default_nettype wire

@@ rtl/pwd_back.sv @@
// Heading unit: shared CORDIC for atan2 and half-angle cos/sin, then result beats.
`default_nettype none

module pwd_back #(
   parameter int POS_WIDTH = 32,
   parameter int ORIENT_WIDTH = 16,
   parameter int CORDIC_STEPS = 16
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      cmd_empty,
   output logic                                      cmd_pop,
   input  logic [pwd_pkg::CTL_WIDTH+6*POS_WIDTH+2*(POS_WIDTH+1)+2*ORIENT_WIDTH-1:0] cmd_data,
   input  logic                                      rsp_full,
   output logic                                      rsp_push,
   output logic [3*POS_WIDTH+2*ORIENT_WIDTH:0]       rsp_data
);
   import pwd_pkg::*;

   localparam int DIFF_WIDTH = POS_WIDTH + 1;
   localparam int STEP_WIDTH = $clog2(CORDIC_STEPS);
   localparam int FRAC       = ORIENT_WIDTH - 1;
   localparam int SHR        = (FRAC <= 30) ? 30 - FRAC : 0;
   localparam int SHL        = (FRAC > 30) ? FRAC - 30 : 0;
   localparam int RND_SH     = (SHR > 0) ? SHR - 1 : 0;
   localparam logic [STEP_WIDTH-1:0] LAST_STEP = STEP_WIDTH'(CORDIC_STEPS - 1);

   // Command fields
   cmd_ctl_type                    c_ctl;
   logic signed [POS_WIDTH-1:0]    c_hx, c_hy, c_hz, c_nx, c_ny, c_nz;
   logic signed [DIFF_WIDTH-1:0]   c_dx, c_dy;
   logic signed [ORIENT_WIDTH-1:0] c_ow, c_oz;

   cmd_ctl_type                    ctl_ff;
   logic signed [POS_WIDTH-1:0]    hx_ff, hy_ff, hz_ff, nx_ff, ny_ff, nz_ff;
   logic signed [ORIENT_WIDTH-1:0] ow_ff, oz_ff;

   // CORDIC state
   logic signed [XY_WIDTH-1:0]     x_ff, y_ff;
   logic signed [ANG_WIDTH-1:0]    ang_ff;
   logic [STEP_WIDTH-1:0]          step_ff;
   back_state_type                 state_ff, state_in;

   logic [4:0]                     k;
   logic signed [ANG_WIDTH-1:0]    atan_k;
   logic signed [XY_WIDTH-1:0]     x_sh, y_sh, mag_y;
   logic                           is_zero, coarse_ok, fine_ok, step_done;
   logic signed [ORIENT_WIDTH-1:0] head_w, head_z;

   function automatic logic signed [ORIENT_WIDTH-1:0] to_orient(
      input logic signed [XY_WIDTH-1:0] q);
      logic signed [XY_WIDTH-1:0] v, hi, lo, rnd;
      hi  = (XY_WIDTH'(1) << FRAC) - XY_WIDTH'(1);
      lo  = -hi - XY_WIDTH'(1);
      rnd = XY_WIDTH'(1) << RND_SH;
      if (SHL > 0) begin
         v = q <<< SHL;
      end else if (SHR > 0) begin
         v = (q + rnd) >>> SHR;
      end else begin
         v = q;
      end
      if (v > hi) begin
         v = hi;
      end else if (v < lo) begin
         v = lo;
      end
      return v[ORIENT_WIDTH-1:0];
   endfunction

   assign {c_ctl, c_hx, c_hy, c_hz, c_nx, c_ny, c_nz, c_dx, c_dy, c_ow, c_oz} = cmd_data;

   assign k         = 5'(step_ff);
   assign atan_k    = atan_lut(k);
   assign x_sh      = x_ff >>> k;
   assign y_sh      = y_ff >>> k;
   assign mag_y     = y_ff[XY_WIDTH-1] ? -y_ff : y_ff;
   assign is_zero   = (x_ff == '0) && (y_ff == '0);
   assign coarse_ok = (x_ff < COARSE_LIMIT) && (mag_y < COARSE_LIMIT);
   assign fine_ok   = (x_ff < NORM_LIMIT) && (mag_y < NORM_LIMIT);
   assign step_done = (step_ff == LAST_STEP);

   // Orientation: passed through for a single point, else from the rotation
   assign head_w = ctl_ff.single ? ow_ff : to_orient(x_ff);
   assign head_z = ctl_ff.single ? oz_ff : to_orient(y_ff);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (!cmd_empty) begin
               state_in = c_ctl.single ? BK_EMIT_LAST : BK_NORM;
            end
         end
         BK_NORM: begin
            if (is_zero) begin
               state_in = BK_HALF;
            end else if (!coarse_ok && !fine_ok) begin
               state_in = BK_VEC;
            end
         end
         BK_VEC: begin
            if (step_done) begin
               state_in = BK_HALF;
            end
         end
         BK_HALF: state_in = BK_ROT;
         BK_ROT: begin
            if (step_done) begin
               state_in = BK_EMIT_HELD;
            end
         end
         BK_EMIT_HELD: begin
            if (!rsp_full) begin
               state_in = ctl_ff.last ? BK_EMIT_LAST : BK_IDLE;
            end
         end
         BK_EMIT_LAST: begin
            if (!rsp_full) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // Outputs: command pop and result beats
   always_comb begin
      cmd_pop  = 1'b0;
      rsp_push = 1'b0;
      rsp_data = {hx_ff, hy_ff, hz_ff, head_w, head_z, 1'b0};
      unique case (state_ff)
         BK_IDLE: cmd_pop = !cmd_empty;
         BK_EMIT_HELD: begin
            rsp_push = !rsp_full;
            rsp_data = {hx_ff, hy_ff, hz_ff, head_w, head_z, 1'b0};
         end
         BK_EMIT_LAST: begin
            rsp_push = !rsp_full;
            rsp_data = {nx_ff, ny_ff, nz_ff, head_w, head_z, 1'b1};
         end
         default: begin
            cmd_pop  = 1'b0;
            rsp_push = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Datapath: load, normalize, vectoring, halve, rotation
   always_ff @(posedge clock) begin
      unique case (state_ff)
         BK_IDLE: begin
            if (!cmd_empty) begin
               ctl_ff  <= c_ctl;
               hx_ff   <= c_hx;
               hy_ff   <= c_hy;
               hz_ff   <= c_hz;
               nx_ff   <= c_nx;
               ny_ff   <= c_ny;
               nz_ff   <= c_nz;
               ow_ff   <= c_ow;
               oz_ff   <= c_oz;
               step_ff <= '0;
               if (c_dx[DIFF_WIDTH-1]) begin
                  x_ff   <= -XY_WIDTH'(c_dx);
                  y_ff   <= -XY_WIDTH'(c_dy);
                  ang_ff <= HALF_TURN;
               end else begin
                  x_ff   <= XY_WIDTH'(c_dx);
                  y_ff   <= XY_WIDTH'(c_dy);
                  ang_ff <= '0;
               end
            end
         end
         BK_NORM: begin
            if (!is_zero && coarse_ok) begin
               x_ff <= x_ff <<< COARSE_SHIFT;
               y_ff <= y_ff <<< COARSE_SHIFT;
            end else if (!is_zero && fine_ok) begin
               x_ff <= x_ff <<< 1;
               y_ff <= y_ff <<< 1;
            end
         end
         BK_VEC: begin
            if (!y_ff[XY_WIDTH-1]) begin
               x_ff   <= x_ff + y_sh;
               y_ff   <= y_ff - x_sh;
               ang_ff <= ang_ff + atan_k;
            end else begin
               x_ff   <= x_ff - y_sh;
               y_ff   <= y_ff + x_sh;
               ang_ff <= ang_ff - atan_k;
            end
            step_ff <= step_ff + 1'b1;
         end
         BK_HALF: begin
            ang_ff  <= ANG_WIDTH'(signed'(ang_ff[31:0]) >>> 1);
            x_ff    <= K_GAIN;
            y_ff    <= '0;
            step_ff <= '0;
         end
         BK_ROT: begin
            if (!ang_ff[ANG_WIDTH-1]) begin
               x_ff   <= x_ff - y_sh;
               y_ff   <= y_ff + x_sh;
               ang_ff <= ang_ff - atan_k;
            end else begin
               x_ff   <= x_ff + y_sh;
               y_ff   <= y_ff - x_sh;
               ang_ff <= ang_ff + atan_k;
            end
            step_ff <= step_ff + 1'b1;
         end
         default: begin
            step_ff <= step_ff;
         end
      endcase
   end

endmodule

`default_nettype wire

@@ rtl/pwd_checker.sv @@
// Port-level checks of the waypoint decimator and their binding to the top level.
`default_nettype none

module pwd_checker (
   input logic        clock,
   input logic        reset,
   input logic        push,
   input logic        full,
   input logic        pop,
   input logic        empty,
   input logic [31:0] rsp_out_x
);

   // The result queue comes out of reset empty and the input side not full
   a_reset_empty: assert property (@(posedge clock) reset |=> empty)
      else $error("result side not empty after reset");

   a_reset_not_full: assert property (@(posedge clock) reset |=> !full)
      else $error("input side full after reset");

   // The input side fills only by taking a beat
   a_full_needs_push: assert property (@(posedge clock) disable iff (reset)
      $rose(full) |-> $past(push))
      else $error("full rose without a push");

   // A waiting result stays until it is taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_out_x)))
      else $error("waiting result dropped or changed");

endmodule

bind path_waypoint_decimator pwd_checker u_pwd_checker (
   .clock     (clock),
   .reset     (reset),
   .push      (push),
   .full      (full),
   .pop       (pop),
   .empty     (empty),
   .rsp_out_x (32'(rsp_out_x))
);

`default_nettype wire
